// ===== design/gpsl_pkg.sv =====
// ----------------------------------------------------------------------------
// gpsl_pkg
// Widths, register indexes and reset values for the gated peak locator.
// ----------------------------------------------------------------------------
package gpsl_pkg;

    localparam int SAMPLE_W  = 16;   // echo sample, two's complement
    localparam int INDEX_W   = 16;   // sample index within one buffer
    localparam int POS_W     = 24;   // Q16.8 position
    localparam int ERR_W     = 25;   // Q.8 error, two's complement
    localparam int HW_W      = 10;   // gate half width
    localparam int CNT_W     = 17;   // sample count register
    localparam int CFG_W     = 24;   // widest register
    localparam int CFG_IDX_W = 2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [INDEX_W-1:0]  t_index;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_POS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_HALF_W  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd2;

    localparam logic [POS_W-1:0] RST_EXPECTED_POS = '0;
    localparam logic [HW_W-1:0]  RST_GATE_HALF_W  = 10'd50;
    localparam logic [CNT_W-1:0] RST_SAMPLE_COUNT = 17'd1024;

endpackage

// ===== design/gated_peak_subsample_locator_core.sv =====
// ----------------------------------------------------------------------------
// gated_peak_subsample_locator_core
// Gated echo peak search with parabolic sub-sample interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall / i_sample) carries one echo buffer as
//   a stream of samples, indices 0 .. sample_count-1, then wraps. Each
//   request updates the gated max search.
//   When the sample just past the gate end is taken, one result is built:
//   a setup state, a 9-step restoring divider (one subtract per cycle,
//   fraction saturated to +-255/256) and a finish state. The input then
//   stalls until the finish state is left; the result then appears on
//   the output channel (o_valid / i_stall). A zero denominator skips the
//   divider. Non-result samples do not stall the input. The output register
//   holds a result until taken; a stalled result only delays the finish
//   cycle, the search state is kept meanwhile. Registers are written through
//   i_cfg_we / i_cfg_index / i_cfg_data while the block is idle; the user
//   must keep to this, the block does not enforce it. Reset (synchronous,
//   active low) restores register defaults, clears the search state and
//   restarts at sample index 0.
// ----------------------------------------------------------------------------
module gated_peak_subsample_locator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample requests
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [gpsl_pkg::SAMPLE_W-1:0] i_sample,
    // result requests
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic        [gpsl_pkg::POS_W-1:0]   o_peak_pos_q8,
    output logic signed [gpsl_pkg::ERR_W-1:0]   o_tof_error_q8,
    output logic                                o_flat_peak,
    output logic                                o_fraction_clipped,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic        [gpsl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [gpsl_pkg::CFG_W-1:0]   i_cfg_data
);
    import gpsl_pkg::*;

    localparam int DIV_W   = 26;   // remainder / shifted divisor
    localparam int STEPS   = 9;    // quotient bits, top one flags overflow
    localparam int STEP_W  = 4;

    typedef enum logic [1:0] {S_IDLE, S_SETUP, S_DIV, S_FIN} t_state;

    t_state              r_state, n_state;
    logic [POS_W-1:0]    r_exp, n_exp;
    logic [HW_W-1:0]     r_hw, n_hw;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    t_index              r_idx, n_idx;
    t_sample             r_prev, n_prev;
    t_sample             r_best_val, n_best_val;
    t_index              r_best_idx, n_best_idx;
    t_sample             r_left, n_left;
    t_sample             r_centre, n_centre;
    t_sample             r_right, n_right;
    logic                r_sent, n_sent;

    logic [DIV_W-1:0]    r_rem, n_rem;
    logic [DIV_W-1:0]    r_dsh, n_dsh;
    logic [STEPS-1:0]    r_quo, n_quo;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_neg, n_neg;
    logic                r_flat, n_flat;

    logic                r_out_valid, n_out_valid;
    logic [POS_W-1:0]    r_peak, n_peak;
    logic [ERR_W-1:0]    r_err, n_err;
    logic                r_oflat, n_oflat;
    logic                r_oclip, n_oclip;

    // gate and search terms
    logic [CNT_W-1:0]        cnt_eff, cnt_m1, cnt_m2, gate_start, gate_end, j_ext;
    logic [CNT_W+7:0]        exp_rnd;
    logic [CNT_W-1:0]        exp_idx;
    logic signed [CNT_W+1:0] gate_lo, gate_hi;
    logic                    accept;
    // setup / divide / finish terms
    logic signed [SAMPLE_W:0]   diff_lr;
    logic signed [SAMPLE_W+1:0] den;
    logic signed [ERR_W-1:0]    num, num_abs;
    logic signed [SAMPLE_W+1:0] den_abs;
    logic [DIV_W:0]             sub;
    logic [7:0]                 frac_mag;
    logic signed [8:0]          frac;
    logic signed [DIV_W-1:0]    peak_full, err_full;

    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);

    assign o_valid            = r_out_valid;
    assign o_peak_pos_q8      = r_peak;
    assign o_tof_error_q8     = r_err;
    assign o_flat_peak        = r_oflat;
    assign o_fraction_clipped = r_oclip;

    always_comb begin
        // effective buffer length, clamped to 3 .. 2^INDEX_W
        if (r_cnt < CNT_W'(3)) begin
            cnt_eff = CNT_W'(3);
        end else if (r_cnt > CNT_W'(1 << INDEX_W)) begin
            cnt_eff = CNT_W'(1 << INDEX_W);
        end else begin
            cnt_eff = r_cnt;
        end
        cnt_m1 = cnt_eff - CNT_W'(1);
        cnt_m2 = cnt_eff - CNT_W'(2);

        exp_rnd = {{CNT_W-16{1'b0}}, r_exp} + (CNT_W+8)'(128);
        exp_idx = exp_rnd[CNT_W+7:8];
        gate_lo = $signed({2'b00, exp_idx}) - $signed({{CNT_W+2-HW_W{1'b0}}, r_hw});
        gate_hi = $signed({2'b00, exp_idx}) + $signed({{CNT_W+2-HW_W{1'b0}}, r_hw});

        if (gate_lo < $signed((CNT_W+2)'(1))) begin
            gate_start = CNT_W'(1);
        end else begin
            gate_start = gate_lo[CNT_W-1:0];
        end
        if (gate_hi > $signed({2'b00, cnt_m2})) begin
            gate_end = cnt_m2;
        end else begin
            gate_end = gate_hi[CNT_W-1:0];
        end
        if (gate_start > gate_end) begin
            gate_start = gate_end;
        end
        j_ext = {1'b0, r_idx};

        // parabola terms from the captured neighbours
        diff_lr = $signed({r_left[SAMPLE_W-1], r_left}) - $signed({r_right[SAMPLE_W-1], r_right});
        num     = $signed({diff_lr, 8'h00});
        den     = $signed({{2{r_left[SAMPLE_W-1]}}, r_left})
                + $signed({{2{r_right[SAMPLE_W-1]}}, r_right})
                - $signed({r_centre[SAMPLE_W-1], r_centre, 1'b0});
        num_abs = num[ERR_W-1] ? -num : num;
        den_abs = den[SAMPLE_W+1] ? -den : den;

        sub = {1'b0, r_rem} - {1'b0, r_dsh};

        frac_mag  = r_quo[STEPS-1] ? 8'hFF : r_quo[7:0];
        frac      = r_neg ? -$signed({1'b0, frac_mag}) : $signed({1'b0, frac_mag});
        peak_full = $signed({2'b00, r_best_idx, 8'h00}) + DIV_W'(frac);
        err_full  = peak_full - $signed({2'b00, r_exp});

        // defaults
        n_state     = r_state;
        n_exp       = r_exp;
        n_hw        = r_hw;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_prev      = r_prev;
        n_best_val  = r_best_val;
        n_best_idx  = r_best_idx;
        n_left      = r_left;
        n_centre    = r_centre;
        n_right     = r_right;
        n_sent      = r_sent;
        n_rem       = r_rem;
        n_dsh       = r_dsh;
        n_quo       = r_quo;
        n_step      = r_step;
        n_neg       = r_neg;
        n_flat      = r_flat;
        n_out_valid = r_out_valid && i_stall;
        n_peak      = r_peak;
        n_err       = r_err;
        n_oflat     = r_oflat;
        n_oclip     = r_oclip;

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXPECTED_POS: n_exp = i_cfg_data;
                CFG_GATE_HALF_W:  n_hw  = i_cfg_data[HW_W-1:0];
                CFG_SAMPLE_COUNT: n_cnt = i_cfg_data[CNT_W-1:0];
                default:          ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_idx == '0) begin
                        n_best_val = '0;
                        n_best_idx = '0;
                        n_left     = '0;
                        n_centre   = '0;
                        n_right    = '0;
                        n_sent     = 1'b0;
                    end
                    if (j_ext == {1'b0, n_best_idx} + CNT_W'(1)) begin
                        n_right = i_sample;
                    end
                    if (j_ext == gate_start) begin
                        n_best_idx = r_idx;
                        n_best_val = (i_sample > 0) ? i_sample : '0;
                        n_left     = r_prev;
                        n_centre   = i_sample;
                    end else if (j_ext > gate_start && j_ext <= gate_end
                                 && i_sample > n_best_val) begin
                        n_best_idx = r_idx;
                        n_best_val = i_sample;
                        n_left     = r_prev;
                        n_centre   = i_sample;
                    end
                    if (j_ext == gate_end + CNT_W'(1) && !n_sent) begin
                        n_sent  = 1'b1;
                        n_state = S_SETUP;
                    end
                    n_prev = i_sample;
                    n_idx  = (j_ext >= cnt_m1) ? '0 : INDEX_W'(j_ext + CNT_W'(1));
                end
            end
            S_SETUP: begin
                // quotient = (|num| + |den|) / (2|den|), halves away from zero
                n_rem  = DIV_W'($unsigned(num_abs)) + DIV_W'($unsigned(den_abs));
                n_dsh  = {den_abs[SAMPLE_W:0], 9'b0};
                n_quo  = '0;
                n_step = '0;
                n_neg  = num[ERR_W-1] ^ den[SAMPLE_W+1];
                n_flat = (den == '0);
                n_state = (den == '0) ? S_FIN : S_DIV;
            end
            S_DIV: begin
                if (!sub[DIV_W]) begin
                    n_rem = sub[DIV_W-1:0];
                end
                n_quo  = {r_quo[STEPS-2:0], ~sub[DIV_W]};
                n_dsh  = r_dsh >> 1;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_peak      = peak_full[POS_W-1:0];
                    n_err       = err_full[ERR_W-1:0];
                    n_oflat     = r_flat;
                    n_oclip     = !r_flat && r_quo[STEPS-1];
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_exp       <= RST_EXPECTED_POS;
            r_hw        <= RST_GATE_HALF_W;
            r_cnt       <= RST_SAMPLE_COUNT;
            r_idx       <= '0;
            r_prev      <= '0;
            r_best_val  <= '0;
            r_best_idx  <= '0;
            r_left      <= '0;
            r_centre    <= '0;
            r_right     <= '0;
            r_sent      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_exp       <= n_exp;
            r_hw        <= n_hw;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_prev      <= n_prev;
            r_best_val  <= n_best_val;
            r_best_idx  <= n_best_idx;
            r_left      <= n_left;
            r_centre    <= n_centre;
            r_right     <= n_right;
            r_sent      <= n_sent;
            r_out_valid <= n_out_valid;
        end
        r_rem   <= n_rem;
        r_dsh   <= n_dsh;
        r_quo   <= n_quo;
        r_step  <= n_step;
        r_neg   <= n_neg;
        r_flat  <= n_flat;
        r_peak  <= n_peak;
        r_err   <= n_err;
        r_oflat <= n_oflat;
        r_oclip <= n_oclip;
    end

endmodule
